// ----- rtl/core/oust_pkg.sv -----
// oust_pkg: constants, request codes and the cell control struct of the
// ordered unique set table; used by oust_cell and ordered_unique_set_table_top
package oust_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int KIND_W   = 3;

   localparam logic [KIND_W-1:0] KIND_ADD      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_GET      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SIZE     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CONTAINS = 3'd4;

   typedef struct packed {
      logic             capture;
      logic             get_mode;
      logic             remove_mode;
      logic             write;
      logic [IDX_W-1:0] wr_idx;
      logic [CNT_W-1:0] count;
      logic [VAL_W-1:0] key;
   } cell_ctl_type;

endpackage

// ----- rtl/core/ordered_unique_set_table_top.sv -----
// ordered_unique_set_table_top: insertion-ordered set of distinct values held
// in a row of oust_cell slots; depends on oust_pkg and oust_cell
//
//   channel   ports                                  handshake
//   request   req_kind, req_value                    start & !busy
//   result    rsp_flag, rsp_number, rsp_status       rsp_valid, one cycle
//
// an accepted item is compared in every cell at once, then a hit and shift
// wave crosses the row one cell per cycle; the strobe comes CAPACITY + 1
// cycles after the accepting edge and the next item may be taken in that
// cycle, so one item every CAPACITY + 2 cycles (258)
// synchronous reset empties the table; stored values are not cleared
// the receiver cannot stall: each result shows for one cycle only
module ordered_unique_set_table_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [oust_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [oust_pkg::VAL_W-1:0]  req_value,
   output logic                               rsp_valid,
   output logic                               rsp_flag,
   output logic signed [oust_pkg::VAL_W-1:0]  rsp_number,
   output logic                               rsp_status
);
   import oust_pkg::*;

   logic              busy_ff, busy_in;
   logic              kick_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [VAL_W-1:0]  key_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff;
   logic              rsp_flag_ff, rsp_flag_in;
   logic [VAL_W-1:0]  rsp_number_ff, rsp_number_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              accept;
   logic              done;
   logic              found;
   logic              wr_en;
   cell_ctl_type      ctl;

   logic             step_w  [CAPACITY+1];
   logic             carry_w [CAPACITY+1];
   logic [VAL_W-1:0] data_w  [CAPACITY+1];
   logic [VAL_W-1:0] entry_w [CAPACITY];

   assign accept = start && !busy_ff;
   assign done   = step_w[CAPACITY];
   assign found  = carry_w[CAPACITY];

   assign ctl.capture     = accept;
   assign ctl.get_mode    = (req_kind == KIND_GET);
   assign ctl.remove_mode = (kind_ff == KIND_REMOVE);
   assign ctl.write       = wr_en;
   assign ctl.wr_idx      = count_ff[IDX_W-1:0];
   assign ctl.count       = count_ff;
   assign ctl.key         = busy_ff ? key_ff : VAL_W'(req_value);

   assign step_w[0]  = kick_ff;
   assign carry_w[0] = 1'b0;
   assign data_w[0]  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VAL_W-1:0] next_entry;
      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = entry_w[i];
      end else begin : g_mid
         assign next_entry = entry_w[i+1];
      end
      oust_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .idx        (IDX_W'(i)),
         .step_in    (step_w[i]),
         .carry_in   (carry_w[i]),
         .data_in    (data_w[i]),
         .next_entry (next_entry),
         .step_out   (step_w[i+1]),
         .carry_out  (carry_w[i+1]),
         .data_out   (data_w[i+1]),
         .entry      (entry_w[i])
      );
   end

   always_comb begin
      busy_in       = busy_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      rsp_flag_in   = 1'b0;
      rsp_number_in = '0;
      rsp_status_in = 1'b0;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (done) begin
         busy_in = 1'b0;
         unique case (kind_ff)
            KIND_ADD: begin
               if (!found) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     rsp_status_in = 1'b1;
                  end else begin
                     rsp_flag_in = 1'b1;
                     wr_en       = 1'b1;
                     count_in    = count_ff + 1'b1;
                  end
               end
            end
            KIND_REMOVE: begin
               rsp_flag_in = found;
               if (found) begin
                  count_in = count_ff - 1'b1;
               end
            end
            KIND_GET: begin
               rsp_number_in = found ? data_w[CAPACITY] : '1;
            end
            KIND_SIZE: begin
               rsp_number_in = VAL_W'(count_ff);
            end
            KIND_CONTAINS: begin
               rsp_flag_in = found;
            end
            default: begin
               rsp_flag_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         kick_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         kick_ff      <= accept;
         count_ff     <= count_in;
         rsp_valid_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         key_ff  <= VAL_W'(req_value);
      end
      rsp_flag_ff   <= rsp_flag_in;
      rsp_number_ff <= rsp_number_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_flag   = rsp_flag_ff;
   assign rsp_number = rsp_number_ff;
   assign rsp_status = rsp_status_ff;

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count beyond capacity");

   a_done_busy : assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff)
      else $error("sweep finished with no item in flight");

   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_count_on_done : assert property (@(posedge clock) disable iff (reset)
      !done |=> (count_ff == $past(count_ff)))
      else $error("count changed outside the end of a sweep");

endmodule

// ----- rtl/core/oust_cell.sv -----
// oust_cell: one table slot; compares on capture, then passes the hit wave,
// the selected data and the step token to its upper neighbor
// depends on oust_pkg
module oust_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  oust_pkg::cell_ctl_type        ctl,
   input  logic [oust_pkg::IDX_W-1:0]    idx,
   input  logic                          step_in,
   input  logic                          carry_in,
   input  logic [oust_pkg::VAL_W-1:0]    data_in,
   input  logic [oust_pkg::VAL_W-1:0]    next_entry,
   output logic                          step_out,
   output logic                          carry_out,
   output logic [oust_pkg::VAL_W-1:0]    data_out,
   output logic [oust_pkg::VAL_W-1:0]    entry
);
   import oust_pkg::*;

   logic             entry_ff;
   logic [VAL_W-1:0] entry_val_ff;
   logic             hit_ff;
   logic             hit_in;
   logic             valid;
   logic             found;
   logic             step_ff;
   logic             carry_ff;
   logic [VAL_W-1:0] data_ff;

   assign valid  = CNT_W'(idx) < ctl.count;
   assign hit_in = valid && (ctl.get_mode ? (ctl.key == VAL_W'(idx))
                                          : (ctl.key == entry_val_ff));
   assign found  = carry_in | hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 1'b0;
         entry_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         entry_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         hit_ff <= hit_in;
      end
      if (step_in) begin
         carry_ff <= found;
         data_ff  <= hit_ff ? entry_val_ff : data_in;
         if (ctl.remove_mode && found) begin
            entry_val_ff <= next_entry;
         end
      end else if (ctl.write && (idx == ctl.wr_idx)) begin
         entry_val_ff <= ctl.key;
      end
   end

   assign step_out  = step_ff & entry_ff;
   assign carry_out = carry_ff;
   assign data_out  = data_ff;
   assign entry     = entry_val_ff;

endmodule
